// ----- hw/rtl/buddy_allocator_core_defines.svh -----
// Assertion macros for the allocator core
`ifndef BUDDY_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/bac_pkg.sv -----
package bac_pkg;

   localparam int MIN_BLOCK_BYTES  = 64;
   localparam int MIN_SHIFT        = $clog2(MIN_BLOCK_BYTES);
   localparam int TOP_ORDER        = 10;
   localparam int HEADER_BYTES     = 32;
   localparam int HEAP_ORDER_RESET = 10;
   localparam int UNITS            = 1 << TOP_ORDER;
   localparam int UNIT_W           = TOP_ORDER;
   localparam int LINK_W           = TOP_ORDER + 1;
   localparam int ORDER_W          = 4;
   localparam int HEADS            = TOP_ORDER + 1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ZERO    = 2'd1,
      STATUS_NOSPACE = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] request_bytes;
      logic [15:0] free_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_address;
      logic [15:0] returned_bytes;
      logic [10:0] live_blocks;
      logic [15:0] bytes_allocated;
      logic [31:0] bytes_freed_total;
      logic [15:0] free_bytes;
      logic [10:0] free_blocks;
      logic        leak_flag;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic               free;
      logic [ORDER_W-1:0] order;
      logic [15:0]        user;
   } meta_type;

   function automatic logic [15:0] payload_of_order(input logic [ORDER_W-1:0] k);
      logic [31:0] size;
      size = 32'(MIN_BLOCK_BYTES) << k;
      return 16'(size - 32'(HEADER_BYTES));
   endfunction

endpackage

// ----- hw/rtl/buddy_allocator_core.sv -----
// Steps from accept to response valid: an allocation runs find, pop and a split step per
// halving; a zero size goes straight to the response and no fitting block ends at find. A
// free checks address and header, then per merge checks the buddy and walks the free list
// in the link memory to unlink it, and pushes the result. One request at a time; the next is
// taken once the response is taken. Reset (synchronous) and every heap_order write start a
// clearing pass over the block memory, during which no request is accepted.
`include "buddy_allocator_core_defines.svh"
module buddy_allocator_core
   import bac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_wdata
);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b000000000001,
      ST_CLEAR   = 12'b000000000010,
      ST_A_FIND  = 12'b000000000100,
      ST_A_POP   = 12'b000000001000,
      ST_A_SPLIT = 12'b000000010000,
      ST_F_ADDR  = 12'b000000100000,
      ST_F_CHK   = 12'b000001000000,
      ST_F_MERGE = 12'b000010000000,
      ST_F_BUDDY = 12'b000100000000,
      ST_F_WALK  = 12'b001000000000,
      ST_F_PUSH  = 12'b010000000000,
      ST_RESP    = 12'b100000000000
   } state_type;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(UNITS);

   state_type           state_ff, state_in;
   logic [ORDER_W-1:0]  ho_ff, ho_in;
   logic [UNIT_W-1:0]   clr_ff, clr_in;
   req_type             req_ff, req_in;
   status_type          status_ff, status_in;
   logic [15:0]         paddr_ff, paddr_in;
   logic [15:0]         fsize_ff, fsize_in;
   logic [ORDER_W-1:0]  want_ff, want_in;
   logic [ORDER_W-1:0]  cur_ff, cur_in;
   logic [ORDER_W-1:0]  k_ff, k_in;
   logic [UNIT_W-1:0]   u_ff, u_in;
   logic [UNIT_W-1:0]   b_ff, b_in;
   logic [LINK_W-1:0]   prev_ff, prev_in;
   logic [LINK_W-1:0]   walk_ff, walk_in;
   logic [LINK_W-1:0]   head_ff [HEADS];
   logic [10:0]         live_ff, live_in;
   logic [15:0]         atot_ff, atot_in;
   logic [31:0]         ftot_ff, ftot_in;
   logic [15:0]         fpay_ff, fpay_in;
   logic [10:0]         fcnt_ff, fcnt_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                head_we;
   logic [ORDER_W-1:0]  head_widx, head_ridx;
   logic [LINK_W-1:0]   head_wdata, head_rd;

   meta_type            meta_mem [UNITS];
   meta_type            meta_rd_ff, meta_wdata;
   logic                meta_we;
   logic [UNIT_W-1:0]   meta_waddr, meta_raddr;

   logic [LINK_W-1:0]   link_mem [UNITS];
   logic [LINK_W-1:0]   link_rd_ff, link_wdata;
   logic                link_we;
   logic [UNIT_W-1:0]   link_waddr, link_raddr;

   logic [16:0]         need;
   logic [ORDER_W-1:0]  want_c, cur_c, nc;
   logic                want_hit, cur_hit;
   logic [15:0]         offs;
   logic [UNIT_W-1:0]   fu, sb;
   logic [32:0]         fsum;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign head_rd   = head_ff[head_ridx];

   always_comb begin
      need     = {1'b0, req_ff.request_bytes} + 17'(HEADER_BYTES);
      want_c   = '0;
      want_hit = 1'b0;
      for (int i = TOP_ORDER; i >= 0; i--) begin
         if ((32'(MIN_BLOCK_BYTES) << i) >= 32'(need)) begin
            want_c   = ORDER_W'(i);
            want_hit = 1'b1;
         end
      end
      cur_c   = '0;
      cur_hit = 1'b0;
      for (int i = TOP_ORDER; i >= 0; i--) begin
         if (ORDER_W'(i) >= want_c && ORDER_W'(i) <= ho_ff && !head_ff[i][UNIT_W]) begin
            cur_c   = ORDER_W'(i);
            cur_hit = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_A_FIND:  head_ridx = cur_c;
         ST_A_SPLIT: head_ridx = cur_ff - ORDER_W'(1);
         default:    head_ridx = k_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ho_in        = ho_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      paddr_in     = paddr_ff;
      fsize_in     = fsize_ff;
      want_in      = want_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      u_in         = u_ff;
      b_in         = b_ff;
      prev_in      = prev_ff;
      walk_in      = walk_ff;
      live_in      = live_ff;
      atot_in      = atot_ff;
      ftot_in      = ftot_ff;
      fpay_in      = fpay_ff;
      fcnt_in      = fcnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      head_we      = 1'b0;
      head_widx    = k_ff;
      head_wdata   = NIL;
      meta_we      = 1'b0;
      meta_waddr   = u_ff;
      meta_wdata   = '0;
      meta_raddr   = u_ff;
      link_we      = 1'b0;
      link_waddr   = u_ff;
      link_wdata   = NIL;
      link_raddr   = u_ff;
      nc           = cur_ff - ORDER_W'(1);
      offs         = req_ff.free_address - 16'(HEADER_BYTES);
      fu           = UNIT_W'(offs >> MIN_SHIFT);
      sb           = (b_ff > u_ff) ? b_ff : u_ff;
      fsum         = {1'b0, ftot_ff} + 33'(meta_rd_ff.user);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               req_in    = req_data;
               status_in = STATUS_OK;
               paddr_in  = '0;
               fsize_in  = '0;
               if (req_data.action == ACTION_ALLOC) begin
                  if (req_data.request_bytes == '0) begin
                     status_in = STATUS_ZERO;
                     state_in  = ST_RESP;
                  end else begin
                     state_in = ST_A_FIND;
                  end
               end else begin
                  state_in = ST_F_ADDR;
               end
            end
         end
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            if (clr_ff == '0) begin
               meta_wdata = '{start: 1'b1, free: 1'b1, order: ho_ff, user: '0};
               link_we    = 1'b1;
               link_waddr = '0;
            end
            clr_in = clr_ff + UNIT_W'(1);
            if (clr_ff == UNIT_W'(UNITS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_A_FIND: begin
            if (!want_hit || want_c > ho_ff || !cur_hit) begin
               status_in = STATUS_NOSPACE;
               state_in  = ST_RESP;
            end else begin
               want_in    = want_c;
               cur_in     = cur_c;
               u_in       = head_rd[UNIT_W-1:0];
               link_raddr = head_rd[UNIT_W-1:0];
               state_in   = ST_A_POP;
            end
         end
         ST_A_POP: begin
            head_we    = 1'b1;
            head_widx  = cur_ff;
            head_wdata = link_rd_ff;
            fpay_in    = fpay_ff - payload_of_order(cur_ff);
            fcnt_in    = fcnt_ff - 11'd1;
            state_in   = ST_A_SPLIT;
         end
         ST_A_SPLIT: begin
            if (cur_ff > want_ff) begin
               meta_we    = 1'b1;
               meta_waddr = u_ff | (UNIT_W'(1) << nc);
               meta_wdata = '{start: 1'b1, free: 1'b1, order: nc, user: '0};
               link_we    = 1'b1;
               link_waddr = u_ff | (UNIT_W'(1) << nc);
               link_wdata = head_rd;
               head_we    = 1'b1;
               head_widx  = nc;
               head_wdata = {1'b0, u_ff | (UNIT_W'(1) << nc)};
               fpay_in    = fpay_ff + payload_of_order(nc);
               fcnt_in    = fcnt_ff + 11'd1;
               cur_in     = nc;
            end else begin
               meta_we    = 1'b1;
               meta_waddr = u_ff;
               meta_wdata = '{start: 1'b1, free: 1'b0, order: want_ff,
                              user: req_ff.request_bytes};
               live_in    = live_ff + 11'd1;
               atot_in    = atot_ff + req_ff.request_bytes;
               paddr_in   = 16'((32'(u_ff) << MIN_SHIFT) + 32'(HEADER_BYTES));
               state_in   = ST_RESP;
            end
         end
         ST_F_ADDR: begin
            if (req_ff.free_address < 16'(HEADER_BYTES) || offs[MIN_SHIFT-1:0] != '0 ||
                ((32'(offs) >> MIN_SHIFT) >> ho_ff) != 32'd0) begin
               status_in = STATUS_INVALID;
               state_in  = ST_RESP;
            end else begin
               u_in       = fu;
               meta_raddr = fu;
               state_in   = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            if (!meta_rd_ff.start || meta_rd_ff.free) begin
               status_in = STATUS_INVALID;
               state_in  = ST_RESP;
            end else begin
               fsize_in = meta_rd_ff.user;
               if (atot_ff >= meta_rd_ff.user) begin
                  atot_in = atot_ff - meta_rd_ff.user;
               end
               ftot_in  = fsum[32] ? 32'hFFFF_FFFF : fsum[31:0];
               live_in  = live_ff - 11'd1;
               k_in     = meta_rd_ff.order;
               state_in = ST_F_MERGE;
            end
         end
         ST_F_MERGE: begin
            meta_we    = 1'b1;
            meta_waddr = u_ff;
            meta_wdata = '{start: 1'b1, free: 1'b1, order: k_ff, user: '0};
            if (k_ff < ho_ff) begin
               b_in       = u_ff ^ (UNIT_W'(1) << k_ff);
               meta_raddr = u_ff ^ (UNIT_W'(1) << k_ff);
               state_in   = ST_F_BUDDY;
            end else begin
               state_in = ST_F_PUSH;
            end
         end
         ST_F_BUDDY: begin
            if (meta_rd_ff.start && meta_rd_ff.free && meta_rd_ff.order == k_ff) begin
               walk_in    = head_rd;
               prev_in    = NIL;
               link_raddr = head_rd[UNIT_W-1:0];
               state_in   = ST_F_WALK;
            end else begin
               state_in = ST_F_PUSH;
            end
         end
         ST_F_WALK: begin
            if (walk_ff[UNIT_W]) begin
               state_in = ST_F_PUSH;
            end else if (walk_ff[UNIT_W-1:0] == b_ff) begin
               if (prev_ff[UNIT_W]) begin
                  head_we    = 1'b1;
                  head_widx  = k_ff;
                  head_wdata = link_rd_ff;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff[UNIT_W-1:0];
                  link_wdata = link_rd_ff;
               end
               fpay_in    = fpay_ff - payload_of_order(k_ff);
               fcnt_in    = fcnt_ff - 11'd1;
               meta_we    = 1'b1;
               meta_waddr = sb;
               meta_wdata = '0;
               u_in       = (b_ff < u_ff) ? b_ff : u_ff;
               k_in       = k_ff + ORDER_W'(1);
               state_in   = ST_F_MERGE;
            end else begin
               prev_in    = walk_ff;
               walk_in    = link_rd_ff;
               link_raddr = link_rd_ff[UNIT_W-1:0];
            end
         end
         ST_F_PUSH: begin
            link_we    = 1'b1;
            link_waddr = u_ff;
            link_wdata = head_rd;
            head_we    = 1'b1;
            head_widx  = k_ff;
            head_wdata = {1'b0, u_ff};
            fpay_in    = fpay_ff + payload_of_order(k_ff);
            fcnt_in    = fcnt_ff + 11'd1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_in.status            = status_ff;
            rsp_in.payload_address   = paddr_ff;
            rsp_in.returned_bytes    = fsize_ff;
            rsp_in.live_blocks       = live_ff;
            rsp_in.bytes_allocated   = atot_ff;
            rsp_in.bytes_freed_total = ftot_ff;
            rsp_in.free_bytes        = fpay_ff;
            rsp_in.free_blocks       = fcnt_ff;
            rsp_in.leak_flag         = {16'd0, atot_ff} != ftot_ff;
            rsp_valid_in             = 1'b1;
            state_in                 = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         ho_in    = (csr_wdata > ORDER_W'(TOP_ORDER)) ? ORDER_W'(TOP_ORDER) : csr_wdata;
         clr_in   = '0;
         state_in = ST_CLEAR;
         live_in  = '0;
         atot_in  = '0;
         ftot_in  = '0;
         fpay_in  = payload_of_order(ho_in);
         fcnt_in  = 11'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ho_ff        <= ORDER_W'(HEAP_ORDER_RESET > TOP_ORDER ? TOP_ORDER : HEAP_ORDER_RESET);
         clr_ff       <= '0;
         live_ff      <= '0;
         atot_ff      <= '0;
         ftot_ff      <= '0;
         fpay_ff      <= payload_of_order(ORDER_W'(HEAP_ORDER_RESET > TOP_ORDER ?
                                                   TOP_ORDER : HEAP_ORDER_RESET));
         fcnt_ff      <= 11'd1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HEADS; i++) begin
            head_ff[i] <= (i == (HEAP_ORDER_RESET > TOP_ORDER ? TOP_ORDER :
                                 HEAP_ORDER_RESET)) ? '0 : NIL;
         end
      end else begin
         state_ff     <= state_in;
         ho_ff        <= ho_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         atot_ff      <= atot_in;
         ftot_ff      <= ftot_in;
         fpay_ff      <= fpay_in;
         fcnt_ff      <= fcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            for (int i = 0; i < HEADS; i++) begin
               head_ff[i] <= (ORDER_W'(i) == ho_in) ? '0 : NIL;
            end
         end else if (head_we) begin
            head_ff[head_widx] <= head_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      paddr_ff  <= paddr_in;
      fsize_ff  <= fsize_in;
      want_ff   <= want_in;
      cur_ff    <= cur_in;
      k_ff      <= k_in;
      u_ff      <= u_in;
      b_ff      <= b_in;
      prev_ff   <= prev_in;
      walk_ff   <= walk_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   `BAC_ASSERT_NOW(a_pop_order, state_ff == ST_A_POP, cur_ff >= want_ff && cur_ff <= ho_ff, "popped order out of range")
   `BAC_ASSERT_NOW(a_paddr_align, rsp_valid_ff && rsp_ff.status == STATUS_OK && rsp_ff.payload_address != '0, rsp_ff.payload_address[MIN_SHIFT-1:0] == MIN_SHIFT'(HEADER_BYTES), "misaligned payload address")
   `BAC_ASSERT_NOW(a_fail_clean, rsp_valid_ff && rsp_ff.status != STATUS_OK, rsp_ff.payload_address == '0 && rsp_ff.returned_bytes == '0, "failed request reports address or size")
   `BAC_ASSERT_NEXT(a_rsp_gap, rsp_valid_ff && rsp_ready, !rsp_valid_ff, "response issued without a request")

endmodule

// ----- bench/testbench.sv -----
module testbench;
   import bac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_wdata = '0;

   buddy_allocator_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   localparam int NIL = UNITS;

   int heap_ord;
   int head_of[HEADS];
   int link_of[UNITS];
   bit is_start[UNITS];
   int order_of[UNITS];
   bit is_free[UNITS];
   int user_of[UNITS];
   int live_cnt;
   int alloc_sum;
   longint freed_sum;
   int free_pay;
   int free_cnt;
   bit live_map[int];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int errors = 0;
   bit quiet = 1'b0;
   bit hold_all = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;

   function automatic int pay_of(int k);
      return ((MIN_BLOCK_BYTES << k) - HEADER_BYTES) & 16'hffff;
   endfunction

   function automatic void push_block(int u, int k);
      link_of[u] = head_of[k];
      head_of[k] = u;
      free_pay = (free_pay + pay_of(k)) & 16'hffff;
      free_cnt++;
   endfunction

   function automatic int pop_block(int k);
      int u;
      u = head_of[k];
      head_of[k] = link_of[u];
      free_pay = (free_pay - pay_of(k)) & 16'hffff;
      free_cnt--;
      return u;
   endfunction

   function automatic bit unlink_block(int u, int k);
      int prev, cur;
      prev = NIL;
      cur = head_of[k];
      for (int g = 0; g <= UNITS && cur < UNITS; g++) begin
         if (cur == u) begin
            if (prev == NIL) head_of[k] = link_of[cur];
            else link_of[prev] = link_of[cur];
            free_pay = (free_pay - pay_of(k)) & 16'hffff;
            free_cnt--;
            return 1'b1;
         end
         prev = cur;
         cur = link_of[cur];
      end
      return 1'b0;
   endfunction

   function automatic void init_heap(int v);
      heap_ord = v > TOP_ORDER ? TOP_ORDER : v;
      for (int i = 0; i < UNITS; i++) begin
         link_of[i] = 0; is_start[i] = 0; order_of[i] = 0; is_free[i] = 0; user_of[i] = 0;
      end
      for (int k = 0; k < HEADS; k++) head_of[k] = NIL;
      is_start[0] = 1; order_of[0] = heap_ord; is_free[0] = 1;
      live_cnt = 0; alloc_sum = 0; freed_sum = 0; free_pay = 0; free_cnt = 0;
      live_map.delete();
      push_block(0, heap_ord);
   endfunction

   function automatic rsp_type allocate_predict(req_type r);
      rsp_type o;
      int need, want, cur, u, b;
      o = '0;
      o.status = STATUS_OK;
      if (r.action == ACTION_ALLOC) begin
         if (r.request_bytes == 0) o.status = STATUS_ZERO;
         else begin
            need = r.request_bytes + HEADER_BYTES;
            want = 0;
            while (want <= heap_ord && (MIN_BLOCK_BYTES << want) < need) want++;
            cur = want;
            while (cur <= heap_ord && head_of[cur] == NIL) cur++;
            if (cur > heap_ord) o.status = STATUS_NOSPACE;
            else begin
               u = pop_block(cur);
               while (cur > want) begin
                  cur--;
                  b = u + (1 << cur);
                  is_start[b] = 1; order_of[b] = cur; is_free[b] = 1; user_of[b] = 0;
                  push_block(b, cur);
               end
               order_of[u] = want; is_free[u] = 0; user_of[u] = r.request_bytes;
               live_cnt++;
               alloc_sum = (alloc_sum + r.request_bytes) & 16'hffff;
               o.payload_address = 16'(u * MIN_BLOCK_BYTES + HEADER_BYTES);
               live_map[u * MIN_BLOCK_BYTES + HEADER_BYTES] = 1'b1;
            end
         end
      end else begin
         int a, k, fs;
         a = r.free_address;
         if (a < HEADER_BYTES || (a - HEADER_BYTES) % MIN_BLOCK_BYTES != 0)
            o.status = STATUS_INVALID;
         else begin
            u = (a - HEADER_BYTES) / MIN_BLOCK_BYTES;
            if (u >= (1 << heap_ord) || !is_start[u] || is_free[u]) o.status = STATUS_INVALID;
            else begin
               live_map.delete(a);
               fs = user_of[u];
               user_of[u] = 0; is_free[u] = 1;
               if (alloc_sum >= fs) alloc_sum -= fs;
               freed_sum += fs;
               if (freed_sum > 64'hffffffff) freed_sum = 64'hffffffff;
               live_cnt--;
               o.returned_bytes = 16'(fs);
               k = order_of[u];
               while (k < heap_ord) begin
                  b = u ^ (1 << k);
                  if (!is_start[b] || !is_free[b] || order_of[b] != k) break;
                  if (!unlink_block(b, k)) break;
                  if (b < u) begin
                     is_start[u] = 0; u = b;
                  end else is_start[b] = 0;
                  k++;
                  order_of[u] = k;
               end
               push_block(u, k);
            end
         end
      end
      o.live_blocks = 11'(live_cnt);
      o.bytes_allocated = 16'(alloc_sum);
      o.bytes_freed_total = 32'(freed_sum);
      o.free_bytes = 16'(free_pay);
      o.free_blocks = 11'(free_cnt);
      o.leak_flag = (alloc_sum != freed_sum);
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(negedge clock) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      if (req_valid && req_ready) begin
      end else if (!req_valid && !reset && !hold_all && pending_reqs.size() > 0
                   && send_gap == 0) begin
         if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 13);
         else begin
            req_data <= pending_reqs[0];
            req_valid <= 1'b1;
         end
      end
      if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         recv_gap <= $urandom_range(1, 13);
         rsp_ready <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if (req_valid && req_ready) begin
         expected_rsps.push_back(allocate_predict(pending_reqs.pop_front()));
         req_valid <= 1'b0;
      end
      if (rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) report_mismatch("unexpected response", 0, 0);
         else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_data.status != e.status)
               report_mismatch("status", rsp_data.status, e.status);
            if (rsp_data.payload_address != e.payload_address)
               report_mismatch("payload_address", rsp_data.payload_address, e.payload_address);
            if (rsp_data.returned_bytes != e.returned_bytes)
               report_mismatch("returned_bytes", rsp_data.returned_bytes, e.returned_bytes);
            if (rsp_data.live_blocks != e.live_blocks)
               report_mismatch("live_blocks", rsp_data.live_blocks, e.live_blocks);
            if (rsp_data.bytes_allocated != e.bytes_allocated)
               report_mismatch("bytes_allocated", rsp_data.bytes_allocated, e.bytes_allocated);
            if (rsp_data.bytes_freed_total != e.bytes_freed_total)
               report_mismatch("bytes_freed_total", rsp_data.bytes_freed_total,
                               e.bytes_freed_total);
            if (rsp_data.free_bytes != e.free_bytes)
               report_mismatch("free_bytes", rsp_data.free_bytes, e.free_bytes);
            if (rsp_data.free_blocks != e.free_blocks)
               report_mismatch("free_blocks", rsp_data.free_blocks, e.free_blocks);
            if (rsp_data.leak_flag != e.leak_flag)
               report_mismatch("leak_flag", rsp_data.leak_flag, e.leak_flag);
         end
      end
   end

   function automatic req_type make_alloc(int n);
      req_type r;
      r = '0;
      r.action = ACTION_ALLOC;
      r.request_bytes = 16'(n);
      r.free_address = 16'($urandom);
      return r;
   endfunction

   function automatic req_type make_free(int a);
      req_type r;
      r = '0;
      r.action = ACTION_FREE;
      r.free_address = 16'(a);
      r.request_bytes = 16'($urandom);
      return r;
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_heap_order(int v);
      @(negedge clock);
      csr_wdata <= 4'(v);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      init_heap(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int rand_size();
      case ($urandom_range(0, 5))
         0: return $urandom_range(1, 32);
         1: return $urandom_range(1, 300);
         2: return $urandom_range(1, 2000);
         3: return (MIN_BLOCK_BYTES << $urandom_range(0, 6)) - HEADER_BYTES
                   + $urandom_range(0, 1);
         4: return $urandom_range(0, 65535);
         default: return $urandom_range(1, 100);
      endcase
   endfunction

   task automatic random_phase(int n);
      int live_addrs[$];
      for (int i = 0; i < n; i++) begin
         int sel;
         sel = $urandom_range(0, 99);
         if (sel < 45) pending_reqs.push_back(make_alloc(rand_size()));
         else if (sel < 85) begin
            if (!hold_all) drain();
            live_addrs.delete();
            foreach (live_map[a]) live_addrs.push_back(a);
            if (live_addrs.size() > 0)
               pending_reqs.push_back(make_free(live_addrs[$urandom_range(0,
                                       live_addrs.size() - 1)]));
            else pending_reqs.push_back(make_alloc(rand_size()));
         end else if (sel < 92)
            pending_reqs.push_back(make_free(HEADER_BYTES
                                   + MIN_BLOCK_BYTES * $urandom_range(0, UNITS - 1)));
         else pending_reqs.push_back(make_free($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      init_heap(HEAP_ORDER_RESET);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      pending_reqs.push_back(make_alloc(0));
      pending_reqs.push_back(make_alloc(65535));
      pending_reqs.push_back(make_alloc((MIN_BLOCK_BYTES << TOP_ORDER) - HEADER_BYTES));
      pending_reqs.push_back(make_free(HEADER_BYTES));
      pending_reqs.push_back(make_free(HEADER_BYTES));
      pending_reqs.push_back(make_alloc(1));
      pending_reqs.push_back(make_alloc(32));
      pending_reqs.push_back(make_alloc(33));
      pending_reqs.push_back(make_free(HEADER_BYTES + MIN_BLOCK_BYTES));
      pending_reqs.push_back(make_free(HEADER_BYTES + 2 * MIN_BLOCK_BYTES));
      pending_reqs.push_back(make_free(HEADER_BYTES + 5 * MIN_BLOCK_BYTES));
      pending_reqs.push_back(make_free(0));
      pending_reqs.push_back(make_free(HEADER_BYTES + 1));
      pending_reqs.push_back(make_free(65535));
      pending_reqs.push_back(make_free(HEADER_BYTES + 700 * MIN_BLOCK_BYTES));
      pending_reqs.push_back(make_free(HEADER_BYTES));
      pending_reqs.push_back(make_alloc(65535));
      drain();

      write_heap_order(0);
      pending_reqs.push_back(make_alloc(32));
      pending_reqs.push_back(make_alloc(1));
      pending_reqs.push_back(make_free(HEADER_BYTES));
      pending_reqs.push_back(make_free(HEADER_BYTES + MIN_BLOCK_BYTES));
      pending_reqs.push_back(make_alloc(33));
      drain();
      write_heap_order(15);
      pending_reqs.push_back(make_alloc((MIN_BLOCK_BYTES << TOP_ORDER) - HEADER_BYTES));
      drain();

      hold_all = 1'b1;
      write_heap_order(3);
      random_phase(150);
      hold_all = 1'b0;
      drain();
      write_heap_order(10);
      random_phase(400);
      drain();
      write_heap_order(6);
      random_phase(250);
      drain();
      write_heap_order($urandom_range(11, 15));
      quiet = 1'b1;
      random_phase(250);
      drain();

      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/bac_pkg.sv
hw/rtl/buddy_allocator_core.sv
bench/testbench.sv
